[design/xss_pkg.sv]
// Shared types and constants for the xoshiro256** generator.
// No dependencies; used by every module of the block.
`default_nettype none

package xss_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CNT_W      = 6;    // bit counter of the serial units
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned IN_TDATA_W = 136;  // 3 + 64 + 64 bits, padded to bytes

  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;

  localparam int unsigned FRAC_SHIFT = 11;   // 64 - 53 fraction bits

  typedef enum logic [CMD_W-1:0] {
    CMD_RAW    = 3'd0,
    CMD_BELOW  = 3'd1,
    CMD_RANGE  = 3'd2,
    CMD_UNIT   = 3'd3,
    CMD_RESEED = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FLOOR,
    ST_FLOOR_WAIT,
    ST_DRAW,
    ST_DRAW2,
    ST_CHECK,
    ST_MOD_WAIT,
    ST_SEED,
    ST_MULA_WAIT,
    ST_MULB_WAIT,
    ST_SEED_FIX,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

[design/xoshiro256ss_random_generator_top.sv]
// xoshiro256** generator with SplitMix64 reseeding: sequencer, state and output register.
// Depends on xss_pkg, xss_serial_mul and xss_serial_rem.
//
// Commands arrive on s_axis, one transfer each; every command gives exactly one result
// transfer on m_axis. The seed register (seed_we_i/seed_wdata_i) is to be written by the user
// only while the block is idle; the block itself does not enforce this. It only takes effect
// at the next reseed command. s_axis_tready is high only in idle, which the sequencer
// enters as the result is loaded, so one command is in flight at a time.
// Sequencer steps per command:
//   raw draw, unit fraction: setup, two draw steps, done. Range with high not above low,
//   unused command: setup, done. Bound zero, full range: setup, floor, done.
//   below a bound / range draw: two passes of the serial remainder unit
//   (rejection floor, then the final modulo), plus a redraw per rejected draw.
//   reseed: four words of two serial multiplies each.
// Reset clears the seed register to 0 and runs the reseed sequence on its own
// (no result) before s_axis_tready rises.
// A finished result waits in the output register while the next command is taken;
// a further result holds in the sequencer until m_axis_tready.
`default_nettype none

module xoshiro256ss_random_generator_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // seed register write
  input  wire logic                           seed_we_i,
  input  wire logic [xss_pkg::WORD_W-1:0]     seed_wdata_i,
  // command stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] cmd, [66:3] limit_or_low, [130:67] range_high, [135:131] zero
  input  wire logic [xss_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [63:0] value
  output logic      [xss_pkg::WORD_W-1:0]     m_axis_tdata
);

  localparam int unsigned W = xss_pkg::WORD_W;

  xss_pkg::state_e state_q, state_d;

  logic [xss_pkg::CMD_W-1:0] cmd_q;
  logic [W-1:0]              lim_q;     // limit_or_low
  logic [W-1:0]              hi_q;      // range_high
  logic [W-1:0]              seed_q;
  logic [3:0][W-1:0]         words_q;
  logic [W-1:0]              acc_q;     // SplitMix64 running counter
  logic [1:0]                idx_q;
  logic                      init_q;    // reseed after reset, no result
  logic [W-1:0]              bound_q;
  logic [W-1:0]              offset_q;
  logic [W-1:0]              floor_q;
  logic [W-1:0]              tmp_q;     // rotl(s1*5, 7)
  logic [W-1:0]              draw_q;
  logic [W-1:0]              res_q;
  logic [W-1:0]              out_q;
  logic                      out_valid_q;

  logic         accept;
  logic         out_load;
  logic         mul_start, mul_done;
  logic [W-1:0] mul_a, mul_b, mul_p;
  logic         rem_start, rem_done;
  logic [W-1:0] rem_n, rem_d, rem_r;

  // draw datapath
  logic [W-1:0] s1x5, draw_now, t2, t3;
  logic [W-1:0] nw0, nw1, nw2, nw3;
  logic [W-1:0] acc_next, mix_a_in, mix_b_in, mix_out;
  logic [W-1:0] span;
  logic         all_zero;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == xss_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);

  assign s1x5     = words_q[1] + {words_q[1][W-3:0], 2'b00};
  assign draw_now = tmp_q + {tmp_q[W-4:0], 3'b000};
  assign t2       = words_q[2] ^ words_q[0];
  assign t3       = words_q[3] ^ words_q[1];
  assign nw0      = words_q[0] ^ t3;
  assign nw1      = words_q[1] ^ t2;
  assign nw2      = t2 ^ {words_q[1][W-18:0], 17'd0};
  assign nw3      = {t3[W-46:0], t3[W-1:W-45]};

  assign acc_next = acc_q + xss_pkg::GOLDEN_GAMMA;
  assign mix_a_in = acc_next ^ (acc_next >> 30);
  assign mix_b_in = mul_p ^ (mul_p >> 27);
  assign mix_out  = mul_p ^ (mul_p >> 31);
  assign span     = hi_q - lim_q + 64'd1;
  assign all_zero = ~|(words_q[0] | words_q[1] | words_q[2] | words_q[3]);

  xss_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  xss_serial_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .num_i   (rem_n),
    .den_i   (rem_d),
    .done_o  (rem_done),
    .rem_o   (rem_r)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      xss_pkg::ST_IDLE: begin
        if (accept) state_d = xss_pkg::ST_SETUP;
      end
      xss_pkg::ST_SETUP: begin
        case (cmd_q)
          xss_pkg::CMD_RAW, xss_pkg::CMD_UNIT: state_d = xss_pkg::ST_DRAW;
          xss_pkg::CMD_BELOW:                  state_d = xss_pkg::ST_FLOOR;
          xss_pkg::CMD_RANGE: begin
            if (hi_q <= lim_q) state_d = xss_pkg::ST_DONE;
            else               state_d = xss_pkg::ST_FLOOR;
          end
          xss_pkg::CMD_RESEED:                 state_d = xss_pkg::ST_SEED;
          default:                             state_d = xss_pkg::ST_DONE;
        endcase
      end
      xss_pkg::ST_FLOOR: begin
        if (bound_q == '0) state_d = xss_pkg::ST_DONE;
        else               state_d = xss_pkg::ST_FLOOR_WAIT;
      end
      xss_pkg::ST_FLOOR_WAIT: begin
        if (rem_done) state_d = xss_pkg::ST_DRAW;
      end
      xss_pkg::ST_DRAW:  state_d = xss_pkg::ST_DRAW2;
      xss_pkg::ST_DRAW2: begin
        if (cmd_q == xss_pkg::CMD_RAW || cmd_q == xss_pkg::CMD_UNIT) begin
          state_d = xss_pkg::ST_DONE;
        end else begin
          state_d = xss_pkg::ST_CHECK;
        end
      end
      xss_pkg::ST_CHECK: begin
        if (draw_q >= floor_q) state_d = xss_pkg::ST_MOD_WAIT;
        else                   state_d = xss_pkg::ST_DRAW;
      end
      xss_pkg::ST_MOD_WAIT: begin
        if (rem_done) state_d = xss_pkg::ST_DONE;
      end
      xss_pkg::ST_SEED: state_d = xss_pkg::ST_MULA_WAIT;
      xss_pkg::ST_MULA_WAIT: begin
        if (mul_done) state_d = xss_pkg::ST_MULB_WAIT;
      end
      xss_pkg::ST_MULB_WAIT: begin
        if (mul_done) begin
          if (idx_q == 2'd3) state_d = xss_pkg::ST_SEED_FIX;
          else               state_d = xss_pkg::ST_SEED;
        end
      end
      xss_pkg::ST_SEED_FIX: begin
        if (init_q) state_d = xss_pkg::ST_IDLE;
        else        state_d = xss_pkg::ST_DONE;
      end
      xss_pkg::ST_DONE: begin
        if (out_load) state_d = xss_pkg::ST_IDLE;
      end
      default: state_d = xss_pkg::ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    mul_a         = mix_a_in;
    mul_b         = xss_pkg::MIX_MUL_A;
    rem_start     = 1'b0;
    rem_n         = '0 - bound_q;
    rem_d         = bound_q;
    case (state_q)
      xss_pkg::ST_IDLE: s_axis_tready = 1'b1;
      xss_pkg::ST_FLOOR: rem_start = (bound_q != '0);
      xss_pkg::ST_CHECK: begin
        rem_start = (draw_q >= floor_q);
        rem_n     = draw_q;
      end
      xss_pkg::ST_SEED: mul_start = 1'b1;
      xss_pkg::ST_MULA_WAIT: begin
        mul_start = mul_done;
        mul_a     = mix_b_in;
        mul_b     = xss_pkg::MIX_MUL_B;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xss_pkg::ST_SEED;
      seed_q      <= '0;
      acc_q       <= '0;
      idx_q       <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (seed_we_i) seed_q <= seed_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        xss_pkg::ST_SETUP: begin
          if (cmd_q == xss_pkg::CMD_RESEED) begin
            acc_q <= seed_q;
            idx_q <= '0;
          end
        end
        xss_pkg::ST_SEED: acc_q <= acc_next;
        xss_pkg::ST_MULB_WAIT: begin
          if (mul_done) idx_q <= idx_q + 2'd1;
        end
        xss_pkg::ST_SEED_FIX: init_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= s_axis_tdata[2:0];
      lim_q <= s_axis_tdata[66:3];
      hi_q  <= s_axis_tdata[130:67];
    end
    if (out_load) out_q <= res_q;
    case (state_q)
      xss_pkg::ST_SETUP: begin
        if (cmd_q == xss_pkg::CMD_RANGE) begin
          offset_q <= lim_q;
          bound_q  <= span;
          res_q    <= lim_q;
        end else begin
          offset_q <= '0;
          bound_q  <= lim_q;
          res_q    <= '0;
        end
      end
      xss_pkg::ST_FLOOR: res_q <= offset_q;
      xss_pkg::ST_FLOOR_WAIT: begin
        if (rem_done) floor_q <= rem_r;
      end
      xss_pkg::ST_DRAW: begin
        tmp_q      <= {s1x5[W-8:0], s1x5[W-1:W-7]};
        words_q[0] <= nw0;
        words_q[1] <= nw1;
        words_q[2] <= nw2;
        words_q[3] <= nw3;
      end
      xss_pkg::ST_DRAW2: begin
        draw_q <= draw_now;
        if (cmd_q == xss_pkg::CMD_UNIT) res_q <= draw_now >> xss_pkg::FRAC_SHIFT;
        else                            res_q <= draw_now;
      end
      xss_pkg::ST_MOD_WAIT: begin
        if (rem_done) res_q <= offset_q + rem_r;
      end
      xss_pkg::ST_MULB_WAIT: begin
        if (mul_done) words_q[idx_q] <= mix_out;
      end
      xss_pkg::ST_SEED_FIX: begin
        res_q <= '0;
        if (all_zero) words_q[0] <= xss_pkg::GOLDEN_GAMMA;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

[design/xss_serial_mul.sv]
// Bit-serial multiplier: low 64 bits of a * b, one multiplier bit per cycle.
// Depends on xss_pkg.
`default_nettype none

module xss_serial_mul (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [xss_pkg::WORD_W-1:0] a_i,
  input  wire logic [xss_pkg::WORD_W-1:0] b_i,
  output logic                            done_o,
  output logic      [xss_pkg::WORD_W-1:0] prod_o
);

  logic                       run_q;
  logic                       done_q;
  logic [xss_pkg::CNT_W-1:0]  cnt_q;
  logic [xss_pkg::WORD_W-1:0] acc_q;
  logic [xss_pkg::WORD_W-1:0] a_q;
  logic [xss_pkg::WORD_W-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // one-cycle pulse after the last bit
      done_q <= run_q && !start_i && (cnt_q == {xss_pkg::CNT_W{1'b1}});
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == {xss_pkg::CNT_W{1'b1}}) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // shift-add datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (run_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[xss_pkg::WORD_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[xss_pkg::WORD_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

[design/xss_serial_rem.sv]
// Restoring remainder unit: n mod d, one dividend bit per cycle.
// Depends on xss_pkg. Divisor must be non-zero.
`default_nettype none

module xss_serial_rem (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [xss_pkg::WORD_W-1:0] num_i,
  input  wire logic [xss_pkg::WORD_W-1:0] den_i,
  output logic                            done_o,
  output logic      [xss_pkg::WORD_W-1:0] rem_o
);

  logic                       run_q;
  logic                       done_q;
  logic [xss_pkg::CNT_W-1:0]  cnt_q;
  logic [xss_pkg::WORD_W-1:0] num_q;
  logic [xss_pkg::WORD_W-1:0] den_q;
  logic [xss_pkg::WORD_W-1:0] rem_q;
  logic [xss_pkg::WORD_W:0]   trial;
  logic [xss_pkg::WORD_W:0]   diff;

  assign trial = {rem_q, num_q[xss_pkg::WORD_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // one-cycle pulse after the last bit
      done_q <= run_q && !start_i && (cnt_q == {xss_pkg::CNT_W{1'b1}});
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == {xss_pkg::CNT_W{1'b1}}) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[xss_pkg::WORD_W-2:0], 1'b0};
      // borrow clear: trial fits, keep difference (always below den)
      if (!diff[xss_pkg::WORD_W]) begin
        rem_q <= diff[xss_pkg::WORD_W-1:0];
      end else begin
        rem_q <= trial[xss_pkg::WORD_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire
